/* design/bcn_pkg.sv */
// shared types and constants for the bc1/bc4 texture block decoder
// no dependencies; imported by every module of the decoder
package bcn_pkg;

	// format_mode register codes; the unused code decodes as opaque bc1
	localparam logic [1:0] FMT_BC1       = 2'd0;
	localparam logic [1:0] FMT_BC1_PUNCH = 2'd1;
	localparam logic [1:0] FMT_BC4       = 2'd2;

	localparam int QUEUE_DEPTH = 2;

	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 40;

	// one classified block waiting for texel emission
	typedef struct packed {
		logic            bc4;
		logic [1:0]      wm1;     // visible columns minus one
		logic [1:0]      hm1;     // visible rows minus one
		logic [7:0][7:0] pr;      // red palette, or the bc4 palette
		logic [3:0][7:0] pg;
		logic [3:0][7:0] pb;
		logic            trans3;  // bc1 entry 3 is transparent black
		logic [47:0]     idx;     // block bits 63:16
	} job_t;

endpackage

/* design/bcn_front.sv */
// front end: takes block beats, clips the tile size and builds the palette
// depends on bcn_pkg; feeds bcn_fifo
module bcn_front import bcn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           format_mode,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	output logic                 q_push,
	input  logic                 q_ready,
	output job_t                 q_job
);

	logic        valid_s1;
	logic [63:0] blk_s1;
	logic [1:0]  wm1_s1, hm1_s1;
	logic        zero_s1, bc4_s1, punch_s1;
	logic        done_s1;
	logic [2:0]  in_w, in_h;

	function automatic logic [1:0] clip_m1(input logic [2:0] v);
		return v[2] ? 2'd3 : 2'(v[1:0] - 2'd1);
	endfunction

	function automatic logic [7:0] lerp7(input logic [7:0] a0, input logic [7:0] a1,
			input logic [2:0] i);
		logic [10:0] s;
		logic [24:0] p;
		s = 11'(a0) * 11'(3'd6 - i) + 11'(a1) * 11'(i) + 11'd3;
		p = 25'(s) * 25'd2341;
		return p[21:14];
	endfunction

	function automatic logic [7:0] lerp5(input logic [7:0] a0, input logic [7:0] a1,
			input logic [2:0] i);
		logic [9:0]  s;
		logic [21:0] p;
		s = 10'(a0) * 10'(3'd4 - i) + 10'(a1) * 10'(i) + 10'd2;
		p = 22'(s) * 22'd820;
		return p[19:12];
	endfunction

	// (2*p0 + p1 + 1) / 3
	function automatic logic [7:0] third(input logic [7:0] p0, input logic [7:0] p1);
		logic [9:0]  s;
		logic [18:0] p;
		s = {1'b0, p0, 1'b0} + {2'b00, p1} + 10'd1;
		p = 19'(s) * 19'd683;
		return p[18:11];
	endfunction

	function automatic logic [7:0] mid(input logic [7:0] p0, input logic [7:0] p1);
		logic [8:0] s;
		s = {1'b0, p0} + {1'b0, p1};
		return s[8:1];
	endfunction

	assign in_w = s_axis_tdata[66:64];
	assign in_h = s_axis_tdata[69:67];

	// empty tiles are dropped without touching the queue
	assign done_s1       = valid_s1 && (zero_s1 || q_ready);
	assign s_axis_tready = !valid_s1 || done_s1;
	assign q_push        = valid_s1 && !zero_s1 && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			blk_s1   <= s_axis_tdata[63:0];
			wm1_s1   <= clip_m1(in_w);
			hm1_s1   <= clip_m1(in_h);
			zero_s1  <= (in_w == 3'd0) || (in_h == 3'd0);
			bc4_s1   <= (format_mode == FMT_BC4);
			punch_s1 <= (format_mode == FMT_BC1_PUNCH);
		end
	end

	always_comb begin
		logic [7:0]  a0, a1;
		logic [15:0] c0, c1;
		logic [7:0]  r0, g0, b0, r1, g1, b1;
		a0 = blk_s1[7:0];
		a1 = blk_s1[15:8];
		c0 = blk_s1[15:0];
		c1 = blk_s1[31:16];
		r0 = {c0[15:11], c0[15:13]};
		g0 = {c0[10:5], c0[10:9]};
		b0 = {c0[4:0], c0[4:2]};
		r1 = {c1[15:11], c1[15:13]};
		g1 = {c1[10:5], c1[10:9]};
		b1 = {c1[4:0], c1[4:2]};
		q_job     = '0;
		q_job.bc4 = bc4_s1;
		q_job.wm1 = wm1_s1;
		q_job.hm1 = hm1_s1;
		q_job.idx = blk_s1[63:16];
		if (bc4_s1) begin
			q_job.pr[0] = a0;
			q_job.pr[1] = a1;
			if (a0 > a1) begin
				for (int i = 1; i < 6; i++) begin
					q_job.pr[i+1] = lerp7(a0, a1, 3'(i));
				end
			end else begin
				for (int i = 1; i < 4; i++) begin
					q_job.pr[i+1] = lerp5(a0, a1, 3'(i));
				end
				q_job.pr[6] = 8'd0;
				q_job.pr[7] = 8'd255;
			end
		end else begin
			q_job.pr[0] = r0;
			q_job.pg[0] = g0;
			q_job.pb[0] = b0;
			q_job.pr[1] = r1;
			q_job.pg[1] = g1;
			q_job.pb[1] = b1;
			if (c0 > c1 || !punch_s1) begin
				q_job.pr[2] = third(r0, r1);
				q_job.pg[2] = third(g0, g1);
				q_job.pb[2] = third(b0, b1);
				q_job.pr[3] = third(r1, r0);
				q_job.pg[3] = third(g1, g0);
				q_job.pb[3] = third(b1, b0);
			end else begin
				q_job.pr[2] = mid(r0, r1);
				q_job.pg[2] = mid(g0, g1);
				q_job.pb[2] = mid(b0, b1);
				q_job.trans3 = 1'b1;
			end
		end
	end

endmodule

/* design/bcn_fifo.sv */
// short job queue between the front end and the texel emitter
// depends on bcn_pkg for the job record
module bcn_fifo import bcn_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic ready,
	output logic valid,
	input  logic pop,
	output job_t pop_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
	endfunction

	assign ready   = (count_q != CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CW'(DEPTH) || pop))
		else $error("job queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("job queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("job queue count out of range");

endmodule

/* design/bcn_back.sv */
// back end: walks the visible texels of one job and registers each result beat
// depends on bcn_pkg; pulls jobs from bcn_fifo
module bcn_back import bcn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  job_t                 q_job,
	output logic                 q_pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic                 m_axis_tlast
);

	job_t       job_q;
	logic       busy_q;
	logic [1:0] x_q, y_q;
	logic       adv, is_last;
	logic [3:0] t;
	logic [2:0] idx3;
	logic [1:0] idx2;
	logic [7:0] red, green, blue, alpha;

	assign adv     = busy_q && (!m_axis_tvalid || m_axis_tready);
	assign is_last = (x_q == job_q.wm1) && (y_q == job_q.hm1);
	assign q_pop   = q_valid && (!busy_q || (adv && is_last));

	assign t    = {y_q, x_q};
	assign idx3 = job_q.idx[6'(t) * 6'd3 +: 3];
	assign idx2 = job_q.idx[6'd16 + {1'b0, t, 1'b0} +: 2];

	always_comb begin
		if (job_q.bc4) begin
			red   = job_q.pr[idx3];
			green = 8'd0;
			blue  = 8'd0;
			alpha = 8'd255;
		end else begin
			red   = job_q.pr[{1'b0, idx2}];
			green = job_q.pg[idx2];
			blue  = job_q.pb[idx2];
			alpha = (job_q.trans3 && idx2 == 2'd3) ? 8'd0 : 8'd255;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			x_q           <= '0;
			y_q           <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				x_q    <= '0;
				y_q    <= '0;
			end else if (adv && is_last) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				if (x_q == job_q.wm1) begin
					x_q <= '0;
					y_q <= y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			if (adv) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (adv) begin
			m_axis_tdata <= {4'd0, alpha, blue, green, red, y_q, x_q};
			m_axis_tlast <= is_last;
		end
	end

	a_walk_in_tile: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (x_q <= job_q.wm1 && y_q <= job_q.hm1))
		else $error("texel walk left the visible tile");
	a_job_runs_to_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !is_last |=> busy_q)
		else $error("job dropped before its last texel");
	a_new_job_starts_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (x_q == 2'd0 && y_q == 2'd0))
		else $error("new job does not start at texel 0,0");

endmodule

/* design/bcn_texture_block_decoder.sv */
// path: front-end stage, job queue, emitter job register, registered texel output
// throughput: one texel beat per cycle while the sink is ready and a job is queued; a
// block emits clipped width*height beats; a zero-size tile emits nothing
// reset: clears all valid flags and queue pointers, format_mode returns to bc1 opaque
// top level: config register, front end, job queue and texel emitter
// depends on bcn_pkg, bcn_front, bcn_fifo, bcn_back
module bcn_texture_block_decoder import bcn_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_data,      // format_mode
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// block_data [63:0], valid_w [66:64], valid_h [69:67], zero pad
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// texel_x [1:0], texel_y [3:2], red [11:4], green [19:12], blue [27:20],
	// alpha [35:28], zero pad
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic                 m_axis_tlast
);

	logic [1:0] format_mode_q;
	logic       q_push, q_ready, q_valid, q_pop;
	job_t       push_job, pop_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= FMT_BC1;
		end else if (cfg_valid && cfg_ready) begin
			format_mode_q <= cfg_data;
		end
	end

	bcn_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.format_mode   (format_mode_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_push        (q_push),
		.q_ready       (q_ready),
		.q_job         (push_job)
	);

	bcn_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.ready    (q_ready),
		.valid    (q_valid),
		.pop      (q_pop),
		.pop_job  (pop_job)
	);

	bcn_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_job         (pop_job),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

/* dv/bcn_texel_checker.sv */
`timescale 1ns / 100ps
// texel checker for the bc1/bc4 block decoder: tracks format_mode, predicts every texel
// beat of each accepted block and compares the output stream against it; uses bcn_pkg
module bcn_texel_checker import bcn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [1:0]           cfg_data,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [M_TDATA_W-1:0] m_axis_tdata,
	input  logic                 m_axis_tlast,
	output int                   err_count,
	output int                   pending,
	output int                   texels_seen
);

	typedef struct packed {
		logic [1:0] x;
		logic [1:0] y;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       last;
	} texel_t;

	texel_t     texel_q[$];
	logic [1:0] fmt_mode;

	initial begin
		err_count   = 0;
		pending     = 0;
		texels_seen = 0;
		fmt_mode    = FMT_BC1;
	end

	function automatic int widen5(int v);
		return ((v << 3) | (v >> 2)) & 255;
	endfunction

	function automatic int widen6(int v);
		return ((v << 2) | (v >> 4)) & 255;
	endfunction

	function automatic void decode_block_texels(logic [63:0] blk, logic [2:0] w_raw,
			logic [2:0] h_raw);
		int     w, h, c0, c1, a0, a1, idx, t;
		int     pr[8], pg[8], pb[8], pa[8];
		logic   is_bc4;
		texel_t tx;
		w = (w_raw > 4) ? 4 : int'(w_raw);
		h = (h_raw > 4) ? 4 : int'(h_raw);
		is_bc4 = (fmt_mode == FMT_BC4);
		if (w == 0 || h == 0)
			return;
		for (int i = 0; i < 8; i++) begin
			pr[i] = 0; pg[i] = 0; pb[i] = 0; pa[i] = 255;
		end
		if (is_bc4) begin
			a0 = int'(blk[7:0]);
			a1 = int'(blk[15:8]);
			pr[0] = a0;
			pr[1] = a1;
			if (a0 > a1) begin
				for (int i = 1; i < 6; i++)
					pr[i + 1] = ((6 - i) * a0 + i * a1 + 3) / 7;
			end else begin
				for (int i = 1; i < 4; i++)
					pr[i + 1] = ((4 - i) * a0 + i * a1 + 2) / 5;
				pr[6] = 0;
				pr[7] = 255;
			end
		end else begin
			c0 = int'(blk[15:0]);
			c1 = int'(blk[31:16]);
			pr[0] = widen5((c0 >> 11) & 'h1F); pg[0] = widen6((c0 >> 5) & 'h3F);
			pb[0] = widen5(c0 & 'h1F);
			pr[1] = widen5((c1 >> 11) & 'h1F); pg[1] = widen6((c1 >> 5) & 'h3F);
			pb[1] = widen5(c1 & 'h1F);
			// the spare code and opaque mode always use the four-color palette
			if (c0 > c1 || fmt_mode != FMT_BC1_PUNCH) begin
				pr[2] = (2 * pr[0] + pr[1] + 1) / 3;
				pg[2] = (2 * pg[0] + pg[1] + 1) / 3;
				pb[2] = (2 * pb[0] + pb[1] + 1) / 3;
				pr[3] = (pr[0] + 2 * pr[1] + 1) / 3;
				pg[3] = (pg[0] + 2 * pg[1] + 1) / 3;
				pb[3] = (pb[0] + 2 * pb[1] + 1) / 3;
			end else begin
				pr[2] = (pr[0] + pr[1]) / 2;
				pg[2] = (pg[0] + pg[1]) / 2;
				pb[2] = (pb[0] + pb[1]) / 2;
				pa[3] = 0;
			end
		end
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				t = y * 4 + x;
				if (is_bc4)
					idx = int'((blk >> (16 + 3 * t)) & 64'd7);
				else
					idx = int'((blk >> (32 + 2 * t)) & 64'd3);
				tx.x    = x[1:0];
				tx.y    = y[1:0];
				tx.r    = pr[idx][7:0];
				tx.g    = pg[idx][7:0];
				tx.b    = pb[idx][7:0];
				tx.a    = pa[idx][7:0];
				tx.last = (y == h - 1) && (x == w - 1);
				texel_q.push_back(tx);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		texel_t got, want;
		if (!arst_n) begin
			fmt_mode = FMT_BC1;
			texel_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				fmt_mode = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				decode_block_texels(s_axis_tdata[63:0], s_axis_tdata[66:64], s_axis_tdata[69:67]);
			if (m_axis_tvalid && m_axis_tready) begin
				got.x    = m_axis_tdata[1:0];
				got.y    = m_axis_tdata[3:2];
				got.r    = m_axis_tdata[11:4];
				got.g    = m_axis_tdata[19:12];
				got.b    = m_axis_tdata[27:20];
				got.a    = m_axis_tdata[35:28];
				got.last = m_axis_tlast;
				texels_seen++;
				if (texel_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%t: texel beat with nothing expected: x=%0d y=%0d rgba=%h%h%h%h last=%b",
							$realtime, got.x, got.y, got.r, got.g, got.b, got.a, got.last);
				end else begin
					want = texel_q.pop_front();
					if (got !== want) begin
						err_count++;
						if (err_count <= 10)
							$display({"%t: texel mismatch: exp x=%0d y=%0d rgba=%h%h%h%h last=%b,",
								" got x=%0d y=%0d rgba=%h%h%h%h last=%b"}, $realtime,
								want.x, want.y, want.r, want.g, want.b, want.a, want.last,
								got.x, got.y, got.r, got.g, got.b, got.a, got.last);
					end
				end
			end
			pending = texel_q.size();
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// top of the bc1/bc4 block decoder testbench: clock, reset, block and format stimulus,
// random stalls on the texel stream; depends on bcn_pkg, the decoder and bcn_texel_checker
module tb_top;
	import bcn_pkg::*;

	localparam logic [1:0] FMT_SPARE = 2'd3;
	localparam int         NUM_PHASES = 7;
	localparam int         RAND_PER_PHASE = 33;
	localparam int         NUM_DIRECTED = 8;

	localparam logic [1:0] PHASE_MODES [NUM_PHASES] = '{FMT_BC1, FMT_BC1_PUNCH, FMT_BC4,
		FMT_SPARE, FMT_BC4, FMT_BC1_PUNCH, FMT_BC1};

	// indices 0..7 repeated fill the bc4 index field; 1b/e4 bytes walk all bc1 indices
	localparam logic [63:0] DIR_BLOCKS [NUM_DIRECTED] = '{
		64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
		64'hE4E4_E4E4_001F_F800, 64'h1B1B_1B1B_F800_07E0,
		64'hFAC6_88FA_C688_10F0, 64'hFAC6_88FA_C688_F010,
		64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210};
	localparam logic [2:0] DIR_W [NUM_DIRECTED] = '{3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd0, 3'd7};
	localparam logic [2:0] DIR_H [NUM_DIRECTED] = '{3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd5};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_data = FMT_BC1;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tlast;

	int   err_count, pending, texels_seen;
	int   blocks_sent = 0;
	int   empty_blocks = 0;
	logic tx_calm = 1'b0;
	logic rx_calm = 1'b0;
	int   rx_wait = 0;

	always #5 clk = ~clk;

	bcn_texture_block_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	bcn_texel_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.err_count     (err_count),
		.pending       (pending),
		.texels_seen   (texels_seen)
	);

	// texel sink: random stall after each beat, with calm stretches that never stall
	always @(posedge clk or negedge arst_n) begin : texel_sink
		int stall;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait       <= 0;
		end else if (m_axis_tready) begin
			if (m_axis_tvalid) begin
				if ($urandom_range(0, 39) == 0)
					rx_calm <= ~rx_calm;
				stall = rx_calm ? 0 : $urandom_range(0, 17);
				if (stall != 0) begin
					m_axis_tready <= 1'b0;
					rx_wait       <= stall - 1;
				end
			end
		end else if (rx_wait == 0) begin
			m_axis_tready <= 1'b1;
		end else begin
			rx_wait <= rx_wait - 1;
		end
	end

	task automatic send_block(logic [63:0] blk, logic [2:0] w, logic [2:0] h);
		int gap;
		if ($urandom_range(0, 29) == 0)
			tx_calm = ~tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, h, w, blk};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		blocks_sent++;
		if (w == 0 || h == 0)
			empty_blocks++;
	endtask

	// stop sending and let every expected texel drain, plus the decoder's pipeline depth
	task automatic drain_decoder();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_format(logic [1:0] mode);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_block();
		logic [63:0] blk;
		logic [2:0]  w, h;
		blk = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: begin
				// equal endpoints in both encodings
				blk[15:8]  = blk[7:0];
				blk[31:16] = blk[15:0];
			end
			1: blk[31:0] = $urandom_range(0, 1) ? 32'h0000_FFFF : 32'hFFFF_0000;
			default: ;
		endcase
		if ($urandom_range(0, 9) == 0) begin
			w = 3'($urandom_range(0, 7));
			h = 3'($urandom_range(0, 7));
		end else begin
			w = 3'($urandom_range(1, 4));
			h = 3'($urandom_range(1, 4));
		end
		send_block(blk, w, h);
	endtask

	initial begin
		#(64'd5_000_000);
		$display("timeout with %0d texels still expected", pending);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_format(PHASE_MODES[p]);
			if (p < 3) begin
				for (int d = 0; d < NUM_DIRECTED; d++)
					send_block(DIR_BLOCKS[d], DIR_W[d], DIR_H[d]);
			end
			for (int r = 0; r < RAND_PER_PHASE; r++)
				send_random_block();
			drain_decoder();
		end
		$display("sent %0d blocks (%0d zero-size) across all four format codes", blocks_sent,
			empty_blocks);
		$display("compared %0d texel beats, %0d mismatches", texels_seen, err_count);
		if (err_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
